[rtl/core/sspj_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspj_pkg - shared constants, types and helpers for sprite projection
// Fixed-point widths, sine polynomial coefficients, register indexes and the
// result record used by the projection pipeline.
// ----------------------------------------------------------------------------
package sspj_pkg;

  localparam int unsigned SINE_TABLE_SIZE_DEF = 1024;

  // sine polynomial, Q30
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [30:0] SIN_C1  = 31'd1686629713;
  localparam logic [30:0] SIN_C3  = 31'd693598668;
  localparam logic [30:0] SIN_C5  = 31'd85569306;
  localparam logic [30:0] SIN_C7  = 31'd5026994;
  localparam logic [30:0] SIN_C9  = 31'd172272;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // 0.1 in Q46
  localparam logic signed [63:0] NEAR_LIMIT = 64'sd7036874417767;

  // divider geometry
  localparam int NUM_W = 95;   // widest dividend
  localparam int QUO_W = 53;   // quotient bits, divisor is at least 2^42
  localparam int DEN_W = 63;   // forward distance, positive Q46
  localparam int LANES = 3;
  localparam int LANE_X = 0;
  localparam int LANE_S = 1;
  localparam int LANE_Y = 2;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAYER_X     = 3'd0,
    REG_PLAYER_Y     = 3'd1,
    REG_PLAYER_ANGLE = 3'd2,
    REG_EYE_HEIGHT   = 3'd3,
    REG_SCREEN_W     = 3'd4,
    REG_SCREEN_H     = 3'd5,
    REG_FOCAL        = 3'd6
  } cfg_reg_t;

  localparam logic [12:0] SCREEN_W_RST = 13'd640;
  localparam logic [12:0] SCREEN_H_RST = 13'd480;
  localparam logic [31:0] FOCAL_RST    = 32'd36323721;

  typedef struct packed {
    logic near;
    logic lat_neg;
    logic dz_neg;
  } side_t;

  typedef struct packed {
    logic        visible;
    logic [31:0] depth;
    logic [31:0] sprite_size;
    logic [31:0] sprite_row;
    logic [31:0] sprite_col;
  } res_t;

  function automatic logic [31:0] sat_s32(input logic signed [55:0] v);
    logic [31:0] r;
    if (v > 56'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -56'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/sprite_screen_projection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_screen_projection - billboard sprite projection for a 1st-person view
// Rotates a sprite offset by the view angle, divides by the forward distance
// and yields screen column, bottom row, size, depth and a visibility flag.
// ----------------------------------------------------------------------------
//  channel   | signals                          | payload
//  ----------+----------------------------------+-------------------------------
//  sprite in | s_axis_tvalid/tready/tdata       | x, y, z (Q16.16), scale (Q8.8)
//  result    | m_axis_tvalid/tready/tdata/tuser | sx, sy, size, depth; visible
//  config    | cfg_wr_en, cfg_index, cfg_data   | one register per write
//
//  One sprite per cycle while the skid entry is empty; the 53-stage divider
//  sits behind an 11-stage sine/rotation/multiply front end.
//  Reset (rst, synchronous) loads register defaults and empties the pipeline.
//  A stalled result parks in a one-entry skid register; the pipeline freezes
//  only while that entry is full, and s_axis_tready is a registered signal.
// ----------------------------------------------------------------------------
module sprite_screen_projection #(
  parameter int unsigned SINE_TABLE_SIZE = sspj_pkg::SINE_TABLE_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [sspj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [111:0]                   s_axis_tdata,  // entity_x, entity_y, entity_z, entity_scale
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [127:0]                   m_axis_tdata,  // sprite_col, sprite_row, sprite_size, depth
  output logic [0:0]                     m_axis_tuser   // visible
);

  localparam int ANGLE_BITS = $clog2(SINE_TABLE_SIZE);
  localparam int QW         = sspj_pkg::QUO_W;
  localparam int NSTAGE     = 11 + QW + 2;

  // configuration
  logic signed [31:0] player_x, player_y, eye_height;
  logic [15:0]        player_angle;
  logic [12:0]        screen_width, screen_height;
  logic [31:0]        focal_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= '0;
      player_y      <= '0;
      player_angle  <= '0;
      eye_height    <= '0;
      screen_width  <= sspj_pkg::SCREEN_W_RST;
      screen_height <= sspj_pkg::SCREEN_H_RST;
      focal_length  <= sspj_pkg::FOCAL_RST;
    end else if (cfg_wr_en) begin
      unique case (sspj_pkg::cfg_reg_t'(cfg_index))
        sspj_pkg::REG_PLAYER_X:     player_x      <= $signed(cfg_data);
        sspj_pkg::REG_PLAYER_Y:     player_y      <= $signed(cfg_data);
        sspj_pkg::REG_PLAYER_ANGLE: player_angle  <= cfg_data[15:0];
        sspj_pkg::REG_EYE_HEIGHT:   eye_height    <= $signed(cfg_data);
        sspj_pkg::REG_SCREEN_W:     screen_width  <= cfg_data[12:0];
        sspj_pkg::REG_SCREEN_H:     screen_height <= cfg_data[12:0];
        sspj_pkg::REG_FOCAL:        focal_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic              en;
  logic              skid_full;
  logic [NSTAGE-1:0] v_q;

  assign en            = !skid_full;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTAGE-2:0], s_axis_tvalid};
    end
  end

  // angle to table phase
  logic [31:0]        phase_sin, phase_cos;
  logic signed [31:0] sn, cs;

  assign phase_sin = {player_angle[15 -: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
  assign phase_cos = phase_sin + sspj_pkg::QUARTER_TURN;

  sspj_sine u_sin (.clk(clk), .en(en), .phase(phase_sin), .sine(sn));
  sspj_sine u_cos (.clk(clk), .en(en), .phase(phase_cos), .sine(cs));

  // stages 0..6: offsets wait for the sine pipeline
  logic signed [32:0] dx_q [0:6];
  logic signed [32:0] dy_q [0:6];
  logic signed [32:0] dz_q [0:7];
  logic [15:0]        scale_q [0:7];

  always_ff @(posedge clk) begin
    if (en) begin
      dx_q[0]    <= $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
                    - $signed({player_x[31], player_x});
      dy_q[0]    <= $signed({s_axis_tdata[63], s_axis_tdata[63:32]})
                    - $signed({player_y[31], player_y});
      dz_q[0]    <= $signed({eye_height[31], eye_height})
                    - $signed({s_axis_tdata[95], s_axis_tdata[95:64]});
      scale_q[0] <= s_axis_tdata[111:96];
      for (int i = 1; i < 7; i++) begin
        dx_q[i] <= dx_q[i-1];
        dy_q[i] <= dy_q[i-1];
      end
      for (int i = 1; i < 8; i++) begin
        dz_q[i]    <= dz_q[i-1];
        scale_q[i] <= scale_q[i-1];
      end
    end
  end

  // stage 7: rotation products
  logic signed [63:0] p_xc, p_ys, p_yc, p_xs;

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= dx_q[6] * cs;
      p_ys <= dy_q[6] * sn;
      p_yc <= dy_q[6] * cs;
      p_xs <= dx_q[6] * sn;
    end
  end

  // stage 8: forward / lateral, height terms
  logic signed [63:0] fwd_q, lat_q;
  logic [45:0]        adz8_q;
  logic [28:0]        hs8_q;
  logic               dzneg8_q;
  logic [32:0]        dz_abs;

  assign dz_abs = dz_q[7][32] ? 33'(-dz_q[7]) : 33'(dz_q[7]);

  always_ff @(posedge clk) begin
    if (en) begin
      fwd_q    <= p_xc + p_ys;
      lat_q    <= p_yc - p_xs;
      adz8_q   <= dz_abs * screen_height;
      hs8_q    <= screen_height * scale_q[7];
      dzneg8_q <= dz_q[7][32];
    end
  end

  // stage 9: split lateral * focal, near test
  logic [62:0]          lat_abs;
  logic [63:0]          lo9_q;
  logic [62:0]          hi9_q;
  logic [sspj_pkg::DEN_W-1:0] den9_q;
  logic [45:0]          adz9_q;
  logic [28:0]          hs9_q;
  sspj_pkg::side_t      side9_q;

  assign lat_abs = lat_q[63] ? 63'(-lat_q) : 63'(lat_q);

  always_ff @(posedge clk) begin
    if (en) begin
      lo9_q           <= lat_abs[31:0] * focal_length;
      hi9_q           <= lat_abs[62:32] * focal_length;
      den9_q          <= fwd_q[62:0];
      adz9_q          <= adz8_q;
      hs9_q           <= hs8_q;
      side9_q.near    <= (fwd_q < sspj_pkg::NEAR_LIMIT);
      side9_q.lat_neg <= lat_q[63];
      side9_q.dz_neg  <= dzneg8_q;
    end
  end

  // stage 10: dividends
  logic [sspj_pkg::LANES-1:0][sspj_pkg::NUM_W-1:0] num_q;
  logic [sspj_pkg::DEN_W-1:0]                      den10_q;
  sspj_pkg::side_t                                 side_q [0:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      num_q[sspj_pkg::LANE_X] <= (sspj_pkg::NUM_W'(hi9_q) << 32) + sspj_pkg::NUM_W'(lo9_q);
      num_q[sspj_pkg::LANE_S] <= sspj_pkg::NUM_W'(hs9_q) << 54;
      num_q[sspj_pkg::LANE_Y] <= sspj_pkg::NUM_W'(adz9_q) << 46;
      den10_q                 <= den9_q;
      side_q[0]               <= side9_q;
      for (int i = 1; i <= QW; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // stages 11..63: division
  logic [sspj_pkg::LANES-1:0][QW-1:0] quo;
  logic [sspj_pkg::DEN_W-1:0]         den_out;

  sspj_div u_div (
    .clk     (clk),
    .en      (en),
    .num     (num_q),
    .den     (den10_q),
    .quo     (quo),
    .den_out (den_out)
  );

  // stage 64: signed offsets
  logic signed [55:0] off_x, off_y, sx_q, sy_q;
  logic [QW-1:0]      size_q;
  logic [32:0]        dep_q;
  logic               near_q;

  assign off_x = $signed({3'b000, quo[sspj_pkg::LANE_X]});
  assign off_y = $signed({3'b000, quo[sspj_pkg::LANE_Y]});

  always_ff @(posedge clk) begin
    if (en) begin
      sx_q   <= (side_q[QW].lat_neg ? -off_x : off_x)
                + $signed({28'b0, screen_width, 15'b0});
      sy_q   <= $signed({28'b0, screen_height, 15'b0})
                + (side_q[QW].dz_neg ? -off_y : off_y);
      size_q <= quo[sspj_pkg::LANE_S];
      dep_q  <= den_out[62:30];
      near_q <= side_q[QW].near;
    end
  end

  // stage 65: visibility and saturation
  logic signed [55:0] size_s, lim_hi;
  logic               vis;
  sspj_pkg::res_t     res_q;

  assign size_s = $signed({3'b000, size_q});
  assign lim_hi = $signed({27'b0, screen_width, 16'b0}) + size_s;
  assign vis    = !near_q && !(sx_q < -size_s || sx_q > lim_hi);

  always_ff @(posedge clk) begin
    if (en) begin
      res_q.visible     <= vis;
      res_q.sprite_col  <= vis ? sspj_pkg::sat_s32(sx_q) : '0;
      res_q.sprite_row  <= vis ? sspj_pkg::sat_s32(sy_q) : '0;
      res_q.sprite_size <= !vis ? '0 : (|size_q[QW-1:32]) ? 32'hFFFF_FFFF : size_q[31:0];
      res_q.depth       <= !vis ? '0 : dep_q[32] ? 32'hFFFF_FFFF : dep_q[31:0];
    end
  end

  // output register with one-entry skid
  sspj_pkg::res_t out_q, skid_q;
  logic           push, out_free;

  assign push     = en && v_q[NSTAGE-1];
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_full     <= 1'b0;
    end else if (skid_full) begin
      if (m_axis_tready) begin
        skid_full <= 1'b0;
      end
    end else if (out_free) begin
      m_axis_tvalid <= push;
    end else if (push) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      if (push) begin
        out_q <= res_q;
      end
    end else if (push) begin
      skid_q <= res_q;
    end
  end

  assign m_axis_tdata = {out_q.depth, out_q.sprite_size, out_q.sprite_row, out_q.sprite_col};
  assign m_axis_tuser = out_q.visible;

endmodule

[rtl/core/sspj_sine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspj_sine - pipelined Q30 sine of a Q0.32 turn fraction
// Quarter-wave odd polynomial in Horner form, at most one multiply per stage.
// Seven register stages; the last one holds the signed result.
// ----------------------------------------------------------------------------
module sspj_sine (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [31:0] sine
);

  logic [1:0]  quad_q [0:5];
  logic [30:0] u_q    [0:5];
  logic [30:0] u2_q   [1:4];
  logic [30:0] t_q    [2:5];

  logic [61:0] p1, p2, p3, p4, p5, p6;
  logic [30:0] s_cl;
  logic [31:0] s32;

  assign p1 = u_q[0] * u_q[0];
  assign p2 = u2_q[1] * sspj_pkg::SIN_C9;
  assign p3 = u2_q[2] * t_q[2];
  assign p4 = u2_q[3] * t_q[3];
  assign p5 = u2_q[4] * t_q[4];
  assign p6 = u_q[5] * t_q[5];

  assign s_cl = (p6[60:30] > sspj_pkg::Q30_ONE) ? sspj_pkg::Q30_ONE : p6[60:30];
  assign s32  = {1'b0, s_cl};

  always_ff @(posedge clk) begin
    if (en) begin
      quad_q[0] <= phase[31:30];
      // odd quadrants run the quarter wave backwards
      u_q[0]    <= phase[30] ? (sspj_pkg::Q30_ONE - {1'b0, phase[29:0]})
                             : {1'b0, phase[29:0]};
      for (int i = 1; i < 6; i++) begin
        quad_q[i] <= quad_q[i-1];
        u_q[i]    <= u_q[i-1];
      end
      u2_q[1] <= p1[60:30];
      for (int i = 2; i < 5; i++) begin
        u2_q[i] <= u2_q[i-1];
      end
      t_q[2] <= sspj_pkg::SIN_C7 - p2[60:30];
      t_q[3] <= sspj_pkg::SIN_C5 - p3[60:30];
      t_q[4] <= sspj_pkg::SIN_C3 - p4[60:30];
      t_q[5] <= sspj_pkg::SIN_C1 - p5[60:30];
      sine   <= quad_q[5][1] ? $signed(32'(-s32)) : $signed(s32);
    end
  end

endmodule

[rtl/core/sspj_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspj_div - pipelined restoring divider, three dividends over one divisor
// One quotient bit per stage per lane. The divisor travels with the item.
// Dividend high bits start below the divisor, so the quotient fits QUO_W.
// ----------------------------------------------------------------------------
module sspj_div (
  input  logic                                                     clk,
  input  logic                                                     en,
  input  logic [sspj_pkg::LANES-1:0][sspj_pkg::NUM_W-1:0]          num,
  input  logic [sspj_pkg::DEN_W-1:0]                               den,
  output logic [sspj_pkg::LANES-1:0][sspj_pkg::QUO_W-1:0]          quo,
  output logic [sspj_pkg::DEN_W-1:0]                               den_out
);

  localparam int QW = sspj_pkg::QUO_W;
  localparam int DW = sspj_pkg::DEN_W;
  localparam int NW = sspj_pkg::NUM_W;
  localparam int LN = sspj_pkg::LANES;

  logic [LN-1:0][DW-1:0] rem_q [0:QW-1];
  logic [LN-1:0][QW-1:0] wrk_q [0:QW-1];   // dividend bits out, quotient bits in
  logic [DW-1:0]         d_q   [0:QW-1];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [LN-1:0][DW-1:0] r_in;
    logic [LN-1:0][QW-1:0] w_in;
    logic [DW-1:0]         d_in;
    logic [LN-1:0][DW-1:0] r_nx;
    logic [LN-1:0][QW-1:0] w_nx;

    always_comb begin
      d_in = (j == 0) ? den : d_q[(j == 0) ? 0 : j-1];
      for (int l = 0; l < LN; l++) begin
        logic [DW:0] t;
        logic        ge;
        if (j == 0) begin
          r_in[l] = DW'(num[l][NW-1:QW]);
          w_in[l] = num[l][QW-1:0];
        end else begin
          r_in[l] = rem_q[(j == 0) ? 0 : j-1][l];
          w_in[l] = wrk_q[(j == 0) ? 0 : j-1][l];
        end
        t       = {r_in[l], w_in[l][QW-1]};
        ge      = (t >= {1'b0, d_in});
        r_nx[l] = ge ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
        w_nx[l] = {w_in[l][QW-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= r_nx;
        wrk_q[j] <= w_nx;
        d_q[j]   <= d_in;
      end
    end
  end

  assign quo     = wrk_q[QW-1];
  assign den_out = d_q[QW-1];

endmodule

[rtl/core/sspj_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sspj_chk - port-level checks for sprite_screen_projection
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module sspj_chk (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser
);

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // hidden sprites carry all-zero fields
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 128'd0)
    else $error("invisible result with non-zero fields");

  // anything visible is past the near limit, so depth is never zero
  a_depth: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[127:96] != 32'd0)
    else $error("visible result with zero depth");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered straight after reset");

endmodule

bind sprite_screen_projection sspj_chk u_sspj_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
